FILE: src/spec_pkg.sv
// Package for the sphere pair collision pipeline: widths, item type, saturation.
package spec_pkg;

    localparam int VW   = 32;            // velocity / offset width
    localparam int DVW  = 33;            // velocity difference magnitude width
    localparam int DDW  = 64;            // squared distance width
    localparam int PW   = DVW + VW;      // |dv_i| * |d_i|
    localparam int ACCW = PW + 3;        // signed dot product
    localparam int AMW  = ACCW - 1;      // dot product magnitude
    localparam int ALW  = 33;            // low slice of the magnitude
    localparam int AHW  = AMW - ALW;     // high slice of the magnitude
    localparam int NW   = 97;            // numerator / remainder width
    localparam int QW   = 34;            // quotient bits, one per divider stage
    localparam int SW   = VW + 4;        // width of the unsaturated sum
    localparam int LAT  = 7 + QW;        // start to o_valid, in cycles

    typedef struct packed {
        logic                 hit;
        logic                 pass;      // no hit or zero offset: velocities pass through
        logic                 negdot;
        logic [2:0]           dneg;
        logic [2:0][VW-1:0]   v1;
        logic [2:0][VW-1:0]   v2;
        logic [DDW-1:0]       dd;
    } t_item;

    function automatic logic [VW-1:0] sat32(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi_lim;
        logic signed [SW-1:0] lo_lim;
        hi_lim = SW'(signed'({1'b0, {(VW-1){1'b1}}}));
        lo_lim = -hi_lim - SW'(1);
        if (x > hi_lim)      sat32 = {1'b0, {(VW-1){1'b1}}};
        else if (x < lo_lim) sat32 = {1'b1, {(VW-1){1'b0}}};
        else                 sat32 = x[VW-1:0];
    endfunction

endpackage

FILE: src/sphere_pair_elastic_collision.sv
// Pipelined equal-mass elastic collision of a sphere pair.
//
//  channel  | handshake       | payload
//  ---------+-----------------+-----------------------------------------------
//  command  | start / busy    | i_offset_*, i_radius_*, i_vel_first_*, i_vel_second_*
//  result   | o_valid strobe  | o_hit, o_new_first_*, o_new_second_*
//
// One item per cycle.
// The 34-stage restoring divider (one quotient bit per stage) sits
// behind six stages of squares, dot product and numerator.
// busy is always low: the receiver cannot stall, so nothing ever waits.
// Reset (synchronous, active low) clears only the valid bits.
module sphere_pair_elastic_collision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_offset_x,
    input  logic [31:0] i_offset_y,
    input  logic [31:0] i_offset_z,
    input  logic [30:0] i_radius_first,
    input  logic [30:0] i_radius_second,
    input  logic [31:0] i_vel_first_x,
    input  logic [31:0] i_vel_first_y,
    input  logic [31:0] i_vel_first_z,
    input  logic [31:0] i_vel_second_x,
    input  logic [31:0] i_vel_second_y,
    input  logic [31:0] i_vel_second_z,
    output logic        o_valid,
    output logic        o_hit,
    output logic [31:0] o_new_first_x,
    output logic [31:0] o_new_first_y,
    output logic [31:0] o_new_first_z,
    output logic [31:0] o_new_second_x,
    output logic [31:0] o_new_second_y,
    output logic [31:0] o_new_second_z
);

    localparam int VW   = spec_pkg::VW;
    localparam int DVW  = spec_pkg::DVW;
    localparam int DDW  = spec_pkg::DDW;
    localparam int PW   = spec_pkg::PW;
    localparam int ACCW = spec_pkg::ACCW;
    localparam int AMW  = spec_pkg::AMW;
    localparam int ALW  = spec_pkg::ALW;
    localparam int AHW  = spec_pkg::AHW;
    localparam int NW   = spec_pkg::NW;
    localparam int QW   = spec_pkg::QW;
    localparam int SW   = spec_pkg::SW;

    logic [2:0][VW-1:0] w_d;
    logic [2:0][VW-1:0] w_v1;
    logic [2:0][VW-1:0] w_v2;

    assign busy = 1'b0;
    assign w_d  = {i_offset_z, i_offset_y, i_offset_x};
    assign w_v1 = {i_vel_first_z, i_vel_first_y, i_vel_first_x};
    assign w_v2 = {i_vel_second_z, i_vel_second_y, i_vel_second_x};

    // ---- stage A: magnitudes and velocity differences ----
    logic               r_a_vld;
    logic [2:0][VW-1:0] r_a_dmag;
    logic [2:0]         r_a_dneg;
    logic [2:0][DVW-1:0] r_a_dvmag;
    logic [2:0]         r_a_dvneg;
    logic [VW-1:0]      r_a_rs;
    logic [2:0][VW-1:0] r_a_v1;
    logic [2:0][VW-1:0] r_a_v2;

    logic [2:0][VW-1:0]  n_a_dmag;
    logic [2:0][DVW-1:0] n_a_dvmag;
    logic [2:0]          n_a_dvneg;

    always_comb begin
        logic signed [DVW-1:0] dv;
        for (int i = 0; i < 3; i++) begin
            n_a_dmag[i]  = w_d[i][VW-1] ? (~w_d[i] + VW'(1)) : w_d[i];
            dv           = DVW'(signed'(w_v2[i])) - DVW'(signed'(w_v1[i]));
            n_a_dvneg[i] = dv[DVW-1];
            n_a_dvmag[i] = dv[DVW-1] ? DVW'(-dv) : DVW'(dv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= start;
        for (int i = 0; i < 3; i++) begin
            r_a_dneg[i] <= w_d[i][VW-1];
        end
        r_a_dmag  <= n_a_dmag;
        r_a_dvmag <= n_a_dvmag;
        r_a_dvneg <= n_a_dvneg;
        r_a_rs    <= VW'(i_radius_first) + VW'(i_radius_second);
        r_a_v1    <= w_v1;
        r_a_v2    <= w_v2;
    end

    // ---- stage B: squares and dot product terms ----
    logic                r_b_vld;
    logic [2:0][DDW-1:0] r_b_dsq;
    logic [2:0][PW-1:0]  r_b_prod;
    logic [2:0]          r_b_pneg;
    logic [DDW-1:0]      r_b_rr;
    logic [2:0]          r_b_dneg;
    logic [2:0][VW-1:0]  r_b_dmag;
    logic [2:0][VW-1:0]  r_b_v1;
    logic [2:0][VW-1:0]  r_b_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
        for (int i = 0; i < 3; i++) begin
            r_b_dsq[i]  <= DDW'(r_a_dmag[i]) * DDW'(r_a_dmag[i]);
            r_b_prod[i] <= PW'(r_a_dvmag[i]) * PW'(r_a_dmag[i]);
            r_b_pneg[i] <= r_a_dvneg[i] ^ r_a_dneg[i];
        end
        r_b_rr   <= DDW'(r_a_rs) * DDW'(r_a_rs);
        r_b_dneg <= r_a_dneg;
        r_b_dmag <= r_a_dmag;
        r_b_v1   <= r_a_v1;
        r_b_v2   <= r_a_v2;
    end

    // ---- stage C: sums and hit test ----
    logic                   r_c_vld;
    spec_pkg::t_item        r_c_it;
    logic signed [ACCW-1:0] r_c_acc;
    logic [2:0][VW-1:0]     r_c_dmag;

    logic [DDW-1:0]         n_c_dd;
    logic signed [ACCW-1:0] n_c_acc;

    always_comb begin
        logic signed [ACCW-1:0] t;
        n_c_dd  = r_b_dsq[0] + r_b_dsq[1] + r_b_dsq[2];
        n_c_acc = '0;
        for (int i = 0; i < 3; i++) begin
            t       = signed'(ACCW'(r_b_prod[i]));
            n_c_acc = n_c_acc + (r_b_pneg[i] ? -t : t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else          r_c_vld <= r_b_vld;
        r_c_it.hit    <= (n_c_dd <= r_b_rr);
        r_c_it.pass   <= (n_c_dd > r_b_rr) || (n_c_dd == '0);
        r_c_it.negdot <= 1'b0;
        r_c_it.dneg   <= r_b_dneg;
        r_c_it.v1     <= r_b_v1;
        r_c_it.v2     <= r_b_v2;
        r_c_it.dd     <= n_c_dd;
        r_c_acc       <= n_c_acc;
        r_c_dmag      <= r_b_dmag;
    end

    // ---- stage D: dot product magnitude ----
    logic               r_d_vld;
    spec_pkg::t_item    r_d_it;
    logic [AMW-1:0]     r_d_amag;
    logic [2:0][VW-1:0] r_d_dmag;

    spec_pkg::t_item    n_d_it;

    always_comb begin
        n_d_it        = r_c_it;
        n_d_it.negdot = r_c_acc[ACCW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else          r_d_vld <= r_c_vld;
        r_d_it   <= n_d_it;
        r_d_amag <= r_c_acc[ACCW-1] ? AMW'(-r_c_acc) : AMW'(r_c_acc);
        r_d_dmag <= r_c_dmag;
    end

    // ---- stage E: numerator partial products ----
    logic                      r_e_vld;
    spec_pkg::t_item           r_e_it;
    logic [2:0][ALW+VW-1:0]    r_e_plo;
    logic [2:0][AHW+VW-1:0]    r_e_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else          r_e_vld <= r_d_vld;
        r_e_it <= r_d_it;
        for (int i = 0; i < 3; i++) begin
            r_e_plo[i] <= (ALW+VW)'(r_d_amag[ALW-1:0]) * (ALW+VW)'(r_d_dmag[i]);
            r_e_phi[i] <= (AHW+VW)'(r_d_amag[AMW-1:ALW]) * (AHW+VW)'(r_d_dmag[i]);
        end
    end

    // ---- stage F: numerator ----
    logic               r_f_vld;
    spec_pkg::t_item    r_f_it;
    logic [2:0][NW-1:0] r_f_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_vld <= 1'b0;
        else          r_f_vld <= r_e_vld;
        r_f_it <= r_e_it;
        for (int i = 0; i < 3; i++) begin
            r_f_num[i] <= (NW'(r_e_phi[i]) << ALW) + NW'(r_e_plo[i]);
        end
    end

    // ---- divider: one quotient bit per stage, MSB first ----
    logic            r_q_vld [QW];
    spec_pkg::t_item r_q_it  [QW];
    logic [2:0][NW-1:0] r_q_rem [QW];
    logic [2:0][QW-1:0] r_q_quo [QW];

    logic [2:0][NW-1:0] w_q_rem [QW];
    logic [2:0][QW-1:0] w_q_quo [QW];
    logic [DDW-1:0]     w_q_dd  [QW];

    logic [2:0][NW-1:0] n_q_rem [QW];
    logic [2:0][QW-1:0] n_q_quo [QW];

    // stage inputs: the numerator for the first stage, the previous stage after that
    always_comb begin
        w_q_rem[0] = r_f_num;
        w_q_quo[0] = '0;
        w_q_dd[0]  = r_f_it.dd;
        for (int k = 1; k < QW; k++) begin
            w_q_rem[k] = r_q_rem[k-1];
            w_q_quo[k] = r_q_quo[k-1];
            w_q_dd[k]  = r_q_it[k-1].dd;
        end
    end

    always_comb begin
        logic [NW-1:0] rem;
        logic [QW-1:0] quo;
        logic [NW-1:0] sub;
        for (int k = 0; k < QW; k++) begin
            for (int i = 0; i < 3; i++) begin
                rem = w_q_rem[k][i];
                quo = w_q_quo[k][i];
                sub = NW'(w_q_dd[k]) << (QW - 1 - k);
                if (rem >= sub) begin
                    n_q_rem[k][i] = rem - sub;
                    n_q_quo[k][i] = quo | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_q_rem[k][i] = rem;
                    n_q_quo[k][i] = quo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_vld[0] <= 1'b0;
        else          r_q_vld[0] <= r_f_vld;
        r_q_it[0] <= r_f_it;
        for (int k = 1; k < QW; k++) begin
            if (!i_rst_n) r_q_vld[k] <= 1'b0;
            else          r_q_vld[k] <= r_q_vld[k-1];
            r_q_it[k] <= r_q_it[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            r_q_rem[k] <= n_q_rem[k];
            r_q_quo[k] <= n_q_quo[k];
        end
    end

    // ---- output stage: apply signed exchange and saturate ----
    spec_pkg::t_item    w_l_it;
    logic [2:0][QW-1:0] w_l_quo;
    logic [2:0][VW-1:0] n_nv1;
    logic [2:0][VW-1:0] n_nv2;

    assign w_l_it  = r_q_it[QW-1];
    assign w_l_quo = r_q_quo[QW-1];

    always_comb begin
        logic signed [SW-1:0] q;
        logic signed [SW-1:0] v1;
        logic signed [SW-1:0] v2;
        for (int i = 0; i < 3; i++) begin
            q  = signed'(SW'(w_l_quo[i]));
            if (w_l_it.negdot ^ w_l_it.dneg[i]) q = -q;
            if (w_l_it.pass) q = '0;
            v1 = SW'(signed'(w_l_it.v1[i]));
            v2 = SW'(signed'(w_l_it.v2[i]));
            n_nv1[i] = spec_pkg::sat32(v1 + q);
            n_nv2[i] = spec_pkg::sat32(v2 - q);
        end
    end

    logic               r_o_vld;
    logic               r_o_hit;
    logic [2:0][VW-1:0] r_o_nv1;
    logic [2:0][VW-1:0] r_o_nv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else          r_o_vld <= r_q_vld[QW-1];
        r_o_hit <= w_l_it.hit;
        r_o_nv1 <= n_nv1;
        r_o_nv2 <= n_nv2;
    end

    assign o_valid        = r_o_vld;
    assign o_hit          = r_o_hit;
    assign o_new_first_x  = r_o_nv1[0];
    assign o_new_first_y  = r_o_nv1[1];
    assign o_new_first_z  = r_o_nv1[2];
    assign o_new_second_x = r_o_nv2[0];
    assign o_new_second_y = r_o_nv2[1];
    assign o_new_second_z = r_o_nv2[2];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(spec_pkg::LAT) o_valid)
        else $error("item lost in pipeline");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, spec_pkg::LAT))
        else $error("result without item");

    a_miss_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld[QW-1] && !w_l_it.hit |=> !o_hit)
        else $error("miss reported as hit");
`endif

endmodule
